@@ hw/rtl/asdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdr_pkg: shared types and constants of the averaged step duty regulator
// Window length, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package asdr_pkg;

    // samples held in the averaging window (2 to 64)
    localparam int WINDOW = 16;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int DUTY_W   = 8;
    localparam int SUM_W    = 16;
    localparam int STEP_W   = 8;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_SUM = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE  = 2'd2;

    // register reset values; the target is the mid-scale sample times window
    localparam logic [SUM_W-1:0]  TARGET_RST = SUM_W'(512 * WINDOW);
    localparam logic [DUTY_W-1:0] LIMIT_RST  = 8'd255;
    localparam logic [STEP_W-1:0] STEP_RST   = 8'd1;

    // stream words
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // regulator settings handed to the datapath
    typedef struct packed {
        logic [SUM_W-1:0]  target_sum;
        logic [DUTY_W-1:0] duty_limit;
        logic [STEP_W-1:0] step_size;
    } t_asdr_cfg;

endpackage

@@ hw/rtl/averaged_step_duty_regulator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaged_step_duty_regulator_unit: moving-sum step duty regulator
// Streams converter samples in and returns the new duty and window sum.
// ----------------------------------------------------------------------------
// Path: an accepted sample waits in the input register, then the regulator
// update loads the result register; a stalled result stream holds it there.
// Throughput: one sample per cycle unless results stall; the combinational
// sum and duty update closes the loop on itself between consecutive samples.
// Reset: synchronous, active low; clears the sample ring, sum, pointer and
// duty, and loads target 512*WINDOW, limit 255 and step 1.
module averaged_step_duty_regulator_unit
    import asdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [9:0] sample, rest zero
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata    // [7:0] duty, [23:8] window_sum
);

    t_asdr_cfg           r_cfg;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    logic [DUTY_W-1:0]   r_out_duty;
    logic [SUM_W-1:0]    r_out_sum;

    logic                w_out_load;
    logic                w_in_load;
    logic [DUTY_W-1:0]   w_duty;
    logic [SUM_W-1:0]    w_sum;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_sum <= TARGET_RST;
            r_cfg.duty_limit <= LIMIT_RST;
            r_cfg.step_size  <= STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TARGET_SUM: r_cfg.target_sum <= i_cfg_wdata;
                CFG_DUTY_LIMIT: r_cfg.duty_limit <= i_cfg_wdata[DUTY_W-1:0];
                CFG_STEP_SIZE:  r_cfg.step_size  <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign w_out_load    = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_out_load;
    assign w_in_load     = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    // regulator datapath
    asdr_regulator u_regulator (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_out_load),
        .i_sample (r_in_sample),
        .i_cfg    (r_cfg),
        .o_duty   (w_duty),
        .o_sum    (w_sum)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_duty <= w_duty;
            r_out_sum  <= w_sum;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_sum, r_out_duty};

endmodule

@@ hw/rtl/asdr_regulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdr_regulator: sample window, running sum and duty stepping
// Holds the sample ring, running sum and duty; one update per enabled cycle.
// ----------------------------------------------------------------------------
module asdr_regulator
    import asdr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_asdr_cfg           i_cfg,
    output logic [DUTY_W-1:0]   o_duty,
    output logic [SUM_W-1:0]    o_sum
);

    logic [SAMPLE_W-1:0] r_ring [WINDOW];
    logic [PTR_W-1:0]    r_ptr;
    logic [SUM_W-1:0]    r_sum;
    logic [DUTY_W-1:0]   r_duty;

    logic [PTR_W-1:0]    n_ptr;
    logic [SUM_W-1:0]    n_sum;
    logic [DUTY_W-1:0]   n_duty;
    logic [DUTY_W:0]     w_up;

    // running sum: add the new sample, drop the one it replaces
    assign n_sum = r_sum + SUM_W'(i_sample) - SUM_W'(r_ring[r_ptr]);

    // pointer wraps at the window end
    assign n_ptr = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;

    // step the duty toward the target, holding where a step would overrun
    assign w_up = {1'b0, r_duty} + {1'b0, i_cfg.step_size};
    always_comb begin
        n_duty = r_duty;
        if (n_sum < i_cfg.target_sum) begin
            if (w_up <= {1'b0, i_cfg.duty_limit}) begin
                n_duty = w_up[DUTY_W-1:0];
            end
        end else if (n_sum > i_cfg.target_sum) begin
            if (r_duty >= i_cfg.step_size) begin
                n_duty = r_duty - i_cfg.step_size;
            end
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_sum  <= '0;
            r_duty <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_en) begin
            r_ptr         <= n_ptr;
            r_sum         <= n_sum;
            r_duty        <= n_duty;
            r_ring[r_ptr] <= i_sample;
        end
    end

    assign o_duty = n_duty;
    assign o_sum  = n_sum;

    // pointer never leaves the window
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) < WINDOW)
        else $error("ring pointer out of window");

    // duty only moves on an update
    a_duty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_duty))
        else $error("duty moved without an update");

    // duty moves by exactly one step or not at all
    a_duty_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> (r_duty == $past(r_duty))
              || (r_duty == $past(r_duty) + $past(i_cfg.step_size))
              || (r_duty == $past(r_duty) - $past(i_cfg.step_size)))
        else $error("duty changed by other than one step");

endmodule
